// ===== rtl/ttcc_pkg.sv =====
// Shared constants, widths and the CORDIC arctangent table for the compass heading core.
`default_nettype none
package ttcc_pkg;

	// CORDIC iterations per unit
	localparam int CORDIC_STAGES = 16;
	// Cycles from an accepted item to its result strobe
	localparam int LATENCY = 2 * CORDIC_STAGES + 8;

	// Datapath widths
	localparam int AW = 34;   // Q30 angle accumulator
	localparam int CW = 33;   // sine/cosine CORDIC vector
	localparam int MW = 26;   // scaled axis, 1/16 mG
	localparam int PW = 58;   // axis times Q30 product
	localparam int HW = 60;   // horizontal field components
	localparam int VW = 62;   // vectoring CORDIC vector

	// Q30 constants
	localparam logic signed [AW-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [31:0]   ONE_Q30     = 32'sd1073741824;
	localparam logic signed [CW-1:0] CORDIC_K    = 33'sd652032874;
	// 128*180/pi in Q16
	localparam logic signed [AW-1:0] DEG_C_Q16   = 34'sd480631834;
	localparam logic signed [17:0]   FULL_TURN   = 18'sd46080;

	// Configuration register indexes
	localparam logic [2:0] REG_GAIN     = 3'd0;
	localparam logic [2:0] REG_OFFSET_X = 3'd1;
	localparam logic [2:0] REG_OFFSET_Y = 3'd2;
	localparam logic [2:0] REG_OFFSET_Z = 3'd3;
	localparam logic [2:0] REG_TILT     = 3'd4;

	// atan(2^-i) in Q30, truncated
	function automatic logic signed [AW-1:0] atan_q30(input int i);
		logic signed [AW-1:0] r;
		case (i)
			0: r = 34'sh03243F6A8;
			1: r = 34'sh01DAC6705;
			2: r = 34'sh00FADBAFC;
			3: r = 34'sh007F56EA6;
			4: r = 34'sh003FEAB76;
			5: r = 34'sh001FFD55B;
			6: r = 34'sh000FFFAAA;
			7: r = 34'sh0007FFF55;
			8: r = 34'sh0003FFFEA;
			9: r = 34'sh0001FFFFD;
			10: r = 34'sh0000FFFFF;
			11: r = 34'sh00007FFFF;
			12: r = 34'sh00003FFFF;
			13: r = 34'sh00001FFFF;
			14: r = 34'sh00000FFFF;
			15: r = 34'sh000007FFF;
			16: r = 34'sh000003FFF;
			17: r = 34'sh000001FFF;
			18: r = 34'sh000000FFF;
			19: r = 34'sh0000007FF;
			20: r = 34'sh0000003FF;
			21: r = 34'sh0000001FF;
			22: r = 34'sh0000000FF;
			23: r = 34'sh00000007F;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/tilt_compensated_compass_heading_core.sv =====
// Top level of the tilt-compensated compass heading pipeline.
//
// Takes one sample per clock: raise start with the sample fields and the item is
// taken at that edge (busy is never raised). Its heading appears on heading and
// zero_field with done high for one cycle once it has passed the two CORDIC
// pipelines of one stage per iteration plus scaling, tilt products, sum and degree
// conversion stages. The result must be taken in that cycle. Write configuration
// only while no item is in flight.
`default_nettype none
module tilt_compensated_compass_heading_core
	import ttcc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_addr,
	input  logic [20:0]        cfg_wdata,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] raw_x,
	input  logic signed [15:0] raw_y,
	input  logic signed [15:0] raw_z,
	input  logic signed [15:0] roll_angle,
	input  logic signed [15:0] pitch_angle,
	output logic               done,
	output logic [15:0]        heading,
	output logic               zero_field
);

	localparam int N = CORDIC_STAGES;

	logic [15:0]          gain_q;
	logic signed [20:0]   off_x_q, off_y_q, off_z_q;
	logic                 tilt_q;
	logic [LATENCY-1:0]   vld_q;

	logic signed [32:0]   gain_ext;
	logic signed [32:0]   px_s1, py_s1, pz_s1;
	logic signed [33:0]   rx, ry, rz;
	logic signed [MW-1:0] m_dly_x_q [0:N];
	logic signed [MW-1:0] m_dly_y_q [0:N];
	logic signed [MW-1:0] m_dly_z_q [0:N];

	logic signed [31:0]   sr, cr, sp, cp;
	logic signed [31:0]   sr_e, cr_e, sp_e, cp_e;
	logic signed [63:0]   spsr_s1, cpsr_s1;
	logic signed [PW-1:0] mxcr_s1, mycp_s1, mzsp_s1;
	logic signed [MW-1:0] my_s1, mz_s1;
	logic signed [31:0]   spsr, cpsr;
	logic signed [PW-1:0] mxcr_s2, myspsr_s2, mzcpsr_s2;
	logic signed [HW-1:0] yh_s2;
	logic signed [HW-1:0] xh_s3, yh_s3;

	logic signed [AW-1:0] vang;
	logic                 vzero;
	logic signed [63:0]   hp_s1;
	logic                 hzero_s1;
	logic signed [63:0]   hround;
	logic signed [17:0]   hraw;
	logic signed [17:0]   hwrap;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= 16'd3768;
			off_x_q <= '0;
			off_y_q <= '0;
			off_z_q <= '0;
			tilt_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_GAIN:     gain_q  <= cfg_wdata[15:0];
				REG_OFFSET_X: off_x_q <= cfg_wdata;
				REG_OFFSET_Y: off_y_q <= cfg_wdata;
				REG_OFFSET_Z: off_z_q <= cfg_wdata;
				REG_TILT:     tilt_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Advance the valid bits; the pipeline never stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], start & ~busy};
		end
	end

	assign busy = 1'b0;
	assign done = vld_q[LATENCY-1];

	// Scale each axis by the gain
	assign gain_ext = {17'b0, gain_q};

	always_ff @(posedge clk) begin
		px_s1 <= 33'(raw_x) * gain_ext;
		py_s1 <= 33'(raw_y) * gain_ext;
		pz_s1 <= 33'(raw_z) * gain_ext;
	end

	// Round, drop the offset, then hold alongside the sine/cosine units
	assign rx = (34'(px_s1) + 34'sd128) >>> 8;
	assign ry = (34'(py_s1) + 34'sd128) >>> 8;
	assign rz = (34'(pz_s1) + 34'sd128) >>> 8;

	always_ff @(posedge clk) begin
		m_dly_x_q[0] <= rx[MW-1:0] - MW'(off_x_q);
		m_dly_y_q[0] <= ry[MW-1:0] - MW'(off_y_q);
		m_dly_z_q[0] <= rz[MW-1:0] - MW'(off_z_q);
	end

	for (genvar k = 0; k < N; k++) begin : g_mdly
		always_ff @(posedge clk) begin
			m_dly_x_q[k+1] <= m_dly_x_q[k];
			m_dly_y_q[k+1] <= m_dly_y_q[k];
			m_dly_z_q[k+1] <= m_dly_z_q[k];
		end
	end

	ttcc_sincos u_roll (
		.clk     (clk),
		.angle   (roll_angle),
		.sin_val (sr),
		.cos_val (cr)
	);

	ttcc_sincos u_pitch (
		.clk     (clk),
		.angle   (pitch_angle),
		.sin_val (sp),
		.cos_val (cp)
	);

	// Tilt off: both angles read as zero
	assign sr_e = tilt_q ? sr : '0;
	assign sp_e = tilt_q ? sp : '0;
	assign cr_e = tilt_q ? cr : ONE_Q30;
	assign cp_e = tilt_q ? cp : ONE_Q30;

	// First product rank
	always_ff @(posedge clk) begin
		spsr_s1 <= 64'(sp_e) * 64'(sr_e);
		cpsr_s1 <= 64'(cp_e) * 64'(sr_e);
		mxcr_s1 <= PW'(m_dly_x_q[N]) * PW'(cr_e);
		mycp_s1 <= PW'(m_dly_y_q[N]) * PW'(cp_e);
		mzsp_s1 <= PW'(m_dly_z_q[N]) * PW'(sp_e);
		my_s1   <= m_dly_y_q[N];
		mz_s1   <= m_dly_z_q[N];
	end

	assign spsr = 32'(spsr_s1 >>> 30);
	assign cpsr = 32'(cpsr_s1 >>> 30);

	// Second product rank and Yh
	always_ff @(posedge clk) begin
		mxcr_s2   <= mxcr_s1;
		myspsr_s2 <= PW'(my_s1) * PW'(spsr);
		mzcpsr_s2 <= PW'(mz_s1) * PW'(cpsr);
		yh_s2     <= HW'(mycp_s1) - HW'(mzsp_s1);
	end

	// Sum Xh
	always_ff @(posedge clk) begin
		xh_s3 <= HW'(mxcr_s2) + HW'(myspsr_s2) - HW'(mzcpsr_s2);
		yh_s3 <= yh_s2;
	end

	ttcc_vector u_vector (
		.clk        (clk),
		.xh         (xh_s3),
		.yh         (yh_s3),
		.angle      (vang),
		.zero_field (vzero)
	);

	// Convert to 1/128 degree
	always_ff @(posedge clk) begin
		hp_s1    <= 64'(vang) * 64'(DEG_C_Q16);
		hzero_s1 <= vzero;
	end

	assign hround = (hp_s1 + (64'sd1 <<< 45)) >>> 46;
	assign hraw   = hround[17:0];

	// Wrap into one turn
	always_comb begin
		hwrap = hraw;
		if (hraw < 0) begin
			hwrap = hraw + FULL_TURN;
		end else if (hraw >= FULL_TURN) begin
			hwrap = hraw - FULL_TURN;
		end
	end

	always_ff @(posedge clk) begin
		heading    <= hzero_s1 ? 16'd0 : hwrap[15:0];
		zero_field <= hzero_s1;
	end

endmodule
`default_nettype wire

// ===== rtl/ttcc_sincos.sv =====
// Pipelined rotation-mode CORDIC: sine and cosine of a Q3.13 angle in Q30.
`default_nettype none
module ttcc_sincos
	import ttcc_pkg::*;
(
	input  logic               clk,
	input  logic signed [15:0] angle,
	output logic signed [31:0] sin_val,
	output logic signed [31:0] cos_val
);

	localparam int N = CORDIC_STAGES;

	logic signed [AW-1:0] a_ext;
	logic signed [AW-1:0] a_red;
	logic                 a_neg;
	logic signed [CW-1:0] cx_q [0:N];
	logic signed [CW-1:0] cy_q [0:N];
	logic signed [AW-1:0] ca_q [0:N];
	logic [N:0]           neg_q;
	logic signed [CW-1:0] cx_neg;
	logic signed [CW-1:0] cy_neg;

	// Fold the angle into -pi/2..pi/2
	always_comb begin
		a_ext = {angle[15], angle, 17'b0};
		a_red = a_ext;
		a_neg = 1'b0;
		if (a_ext > HALF_PI_Q30) begin
			a_red = a_ext - PI_Q30;
			a_neg = 1'b1;
		end else if (a_ext < -HALF_PI_Q30) begin
			a_red = a_ext + PI_Q30;
			a_neg = 1'b1;
		end
	end

	// Load the first stage
	always_ff @(posedge clk) begin
		cx_q[0]  <= CORDIC_K;
		cy_q[0]  <= '0;
		ca_q[0]  <= a_red;
		neg_q[0] <= a_neg;
	end

	// Rotate one step per stage
	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (!ca_q[i][AW-1]) begin
				cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
				cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
				ca_q[i+1] <= ca_q[i] - atan_q30(i);
			end else begin
				cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
				cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
				ca_q[i+1] <= ca_q[i] + atan_q30(i);
			end
			neg_q[i+1] <= neg_q[i];
		end
	end

	assign cx_neg = -cx_q[N];
	assign cy_neg = -cy_q[N];

	// Undo the fold and register the result
	always_ff @(posedge clk) begin
		cos_val <= neg_q[N] ? cx_neg[31:0] : cx_q[N][31:0];
		sin_val <= neg_q[N] ? cy_neg[31:0] : cy_q[N][31:0];
	end

endmodule
`default_nettype wire

// ===== rtl/ttcc_vector.sv =====
// Pipelined vectoring-mode CORDIC: Q30 angle of the horizontal field.
`default_nettype none
module ttcc_vector
	import ttcc_pkg::*;
(
	input  logic                 clk,
	input  logic signed [HW-1:0] xh,
	input  logic signed [HW-1:0] yh,
	output logic signed [AW-1:0] angle,
	output logic                 zero_field
);

	localparam int N = CORDIC_STAGES;

	logic signed [VW-1:0] x_ext;
	logic signed [VW-1:0] y_ext;
	logic signed [VW-1:0] vx_q [0:N];
	logic signed [VW-1:0] vy_q [0:N];
	logic signed [AW-1:0] vz_q [0:N];
	logic [N:0]           zero_q;

	assign x_ext = VW'(xh);
	assign y_ext = VW'(yh);

	// Move the left half plane over and flag a zero field
	always_ff @(posedge clk) begin
		if (xh[HW-1]) begin
			vx_q[0] <= -x_ext;
			vy_q[0] <= -y_ext;
			vz_q[0] <= PI_Q30;
		end else begin
			vx_q[0] <= x_ext;
			vy_q[0] <= y_ext;
			vz_q[0] <= '0;
		end
		zero_q[0] <= (xh == '0) && (yh == '0);
	end

	// Drive y toward zero one step per stage
	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (vy_q[i] > 0) begin
				vx_q[i+1] <= vx_q[i] + (vy_q[i] >>> i);
				vy_q[i+1] <= vy_q[i] - (vx_q[i] >>> i);
				vz_q[i+1] <= vz_q[i] + atan_q30(i);
			end else begin
				vx_q[i+1] <= vx_q[i] - (vy_q[i] >>> i);
				vy_q[i+1] <= vy_q[i] + (vx_q[i] >>> i);
				vz_q[i+1] <= vz_q[i] - atan_q30(i);
			end
			zero_q[i+1] <= zero_q[i];
		end
	end

	assign angle      = vz_q[N];
	assign zero_field = zero_q[N];

endmodule
`default_nettype wire

// ===== rtl/ttcc_checker.sv =====
// Port-level checker for the compass heading core, with its bind.
`default_nettype none
module ttcc_checker
	import ttcc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [15:0] heading,
	input logic        zero_field
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without a matching item");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (heading < 16'd46080))
		else $error("heading out of range");

	a_zero_heading: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_field) |-> (heading == 16'd0))
		else $error("zero field with nonzero heading");

endmodule

bind tilt_compensated_compass_heading_core ttcc_checker u_ttcc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.heading    (heading),
	.zero_field (zero_field)
);
`default_nettype wire

// ===== test/tilt_compensated_compass_heading_checker.sv =====
// Heading predictor and result scoreboard for the compass heading core.
`timescale 1ns / 100ps
module tilt_compensated_compass_heading_checker
	import ttcc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_addr,
	input  logic [20:0]        cfg_wdata,
	input  logic               start,
	input  logic               busy,
	input  logic signed [15:0] raw_x,
	input  logic signed [15:0] raw_y,
	input  logic signed [15:0] raw_z,
	input  logic signed [15:0] roll_angle,
	input  logic signed [15:0] pitch_angle,
	input  logic               done,
	input  logic [15:0]        heading,
	input  logic               zero_field,
	output int                 pending,
	output int                 fail_count,
	output int                 headings_seen
);

	typedef struct packed {
		logic [15:0] heading;
		logic        zero_field;
	} heading_t;

	localparam longint Q_PI = 64'sd3373259426;
	localparam longint Q_HALF_PI = 64'sd1686629713;
	localparam longint Q_ONE = 64'sd1073741824;
	localparam longint START_GAIN = 64'sd652032874;
	localparam longint TO_DEG = 64'sd480631834;
	localparam longint TURN = 64'sd46080;

	longint arctan_q30 [24] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
	};

	logic [15:0]  gain_q12;
	longint       off_x, off_y, off_z;
	logic         tilt_on;
	heading_t     expected_headings [$];

	// rotate the start vector by the angle; fold angles beyond a quarter turn
	task automatic rotate_unit(input longint ang, output longint s, output longint c);
		longint x, y, t;
		logic flip;
		int n;
		x = START_GAIN;
		y = 0;
		flip = 1'b0;
		n = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
		if (ang > Q_HALF_PI) begin
			ang -= Q_PI;
			flip = 1'b1;
		end else if (ang < -Q_HALF_PI) begin
			ang += Q_PI;
			flip = 1'b1;
		end
		for (int i = 0; i < n; i++) begin
			if (ang >= 0) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				ang -= arctan_q30[i];
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				ang += arctan_q30[i];
			end
			x = t;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	// vectoring arctangent; left half plane starts at pi
	function automatic longint vector_angle(input longint x, input longint y);
		longint z, t;
		int n;
		z = 0;
		n = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = Q_PI;
		end
		for (int i = 0; i < n; i++) begin
			if (y > 0) begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z += arctan_q30[i];
			end else begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z -= arctan_q30[i];
			end
			x = t;
		end
		return z;
	endfunction

	function automatic longint scale_count(input logic signed [15:0] raw, input longint off);
		longint p;
		p = longint'(raw) * longint'({1'b0, gain_q12});
		return ((p + 128) >>> 8) - off;
	endfunction

	task automatic predict_heading(output heading_t r);
		longint mx, my, mz, sr, cr, sp, cp, spsr, cpsr, xh, yh, h;
		mx = scale_count(raw_x, off_x);
		my = scale_count(raw_y, off_y);
		mz = scale_count(raw_z, off_z);
		sr = 0;
		cr = Q_ONE;
		sp = 0;
		cp = Q_ONE;
		if (tilt_on) begin
			rotate_unit(longint'(roll_angle) * 131072, sr, cr);
			rotate_unit(longint'(pitch_angle) * 131072, sp, cp);
		end
		spsr = (sp * sr) >>> 30;
		cpsr = (cp * sr) >>> 30;
		xh = mx * cr + my * spsr - mz * cpsr;
		yh = my * cp - mz * sp;
		if (xh == 0 && yh == 0) begin
			r.heading = '0;
			r.zero_field = 1'b1;
		end else begin
			h = (vector_angle(xh, yh) * TO_DEG + (64'sd1 <<< 45)) >>> 46;
			if (h < 0)
				h += TURN;
			if (h >= TURN)
				h -= TURN;
			r.heading = h[15:0];
			r.zero_field = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("%0t ns: heading mismatch: %s", $time, what);
		fail_count++;
	endtask

	// track register writes, queue predictions, compare each strobed result
	always @(posedge clk or negedge arst_n) begin
		heading_t exp_r;
		heading_t got_r;
		if (!arst_n) begin
			gain_q12 <= 16'd3768;
			off_x <= 0;
			off_y <= 0;
			off_z <= 0;
			tilt_on <= 1'b1;
			expected_headings.delete();
			pending <= 0;
			fail_count = 0;
			headings_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_GAIN:     gain_q12 <= cfg_wdata[15:0];
					REG_OFFSET_X: off_x <= longint'($signed(cfg_wdata));
					REG_OFFSET_Y: off_y <= longint'($signed(cfg_wdata));
					REG_OFFSET_Z: off_z <= longint'($signed(cfg_wdata));
					REG_TILT:     tilt_on <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (done) begin
				headings_seen++;
				got_r.heading = heading;
				got_r.zero_field = zero_field;
				if (expected_headings.size() == 0) begin
					report_mismatch($sformatf("unexpected result heading=%0d", heading));
				end else begin
					exp_r = expected_headings.pop_front();
					if (got_r.heading !== exp_r.heading)
						report_mismatch($sformatf("heading got %0d want %0d",
							got_r.heading, exp_r.heading));
					if (got_r.zero_field !== exp_r.zero_field)
						report_mismatch($sformatf("zero_field got %b want %b",
							got_r.zero_field, exp_r.zero_field));
				end
			end
			if (start && !busy) begin
				predict_heading(exp_r);
				expected_headings.push_back(exp_r);
			end
			pending <= expected_headings.size();
		end
	end

endmodule

// ===== test/tilt_compensated_compass_heading_core_test.sv =====
// Stimulus and verdict for the compass heading core.
`timescale 1ns / 100ps
module tilt_compensated_compass_heading_core_test;
	import ttcc_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int ANGLE_MAX = 25736;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_addr = '0;
	logic [20:0]        cfg_wdata = '0;
	logic               start = 1'b0;
	logic               busy;
	logic               busy_n;
	logic signed [15:0] raw_x = '0;
	logic signed [15:0] raw_y = '0;
	logic signed [15:0] raw_z = '0;
	logic signed [15:0] roll_angle = '0;
	logic signed [15:0] pitch_angle = '0;
	logic               done;
	logic [15:0]        heading;
	logic               zero_field;
	int                 pending;
	int                 fail_count;
	int                 headings_seen;
	int                 cycles = 0;
	int                 samples_sent = 0;
	int                 settings_used = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	tilt_compensated_compass_heading_core uut (.*);

	tilt_compensated_compass_heading_checker chk (.*);

	// busy as it stood before the coming edge
	always @(negedge clk)
		busy_n <= busy;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z, input logic [15:0] r, input logic [15:0] p);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		raw_x <= x;
		raw_y <= y;
		raw_z <= z;
		roll_angle <= r;
		pitch_angle <= p;
		do @(posedge clk); while (busy_n);
		samples_sent++;
	endtask

	// hold off until every queued heading has come back
	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [20:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_setting(input logic [15:0] g, input logic [20:0] ox,
			input logic [20:0] oy, input logic [20:0] oz, input logic t);
		drain();
		write_reg(REG_GAIN, {5'd0, g});
		write_reg(REG_OFFSET_X, ox);
		write_reg(REG_OFFSET_Y, oy);
		write_reg(REG_OFFSET_Z, oz);
		write_reg(REG_TILT, {20'd0, t});
		settings_used++;
	endtask

	function automatic logic [15:0] pick_angle();
		if ($urandom_range(0, 7) == 0)
			return 16'($urandom);
		return 16'($signed($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX);
	endfunction

	function automatic logic [15:0] pick_count();
		case ($urandom_range(0, 5))
			0: return 16'($signed($urandom_range(0, 16)) - 8);
			1: return 16'h8000;
			2: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_burst(input int n);
		for (int i = 0; i < n; i++)
			send_sample(pick_count(), pick_count(), pick_count(), pick_angle(), pick_angle());
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero field, extremes, angles past pi and at quarter turns
		send_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_sample(16'd0, 16'd0, 16'd0, 16'd5000, 16'hE000);
		send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd25736, 16'd25736);
		send_sample(16'h8000, 16'h8000, 16'h8000, -16'sd25736, -16'sd25736);
		send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
		send_sample(16'h8000, 16'h7FFF, 16'h0000, 16'd12868, -16'sd12868);
		send_sample(16'd1000, 16'hFFFF, 16'd0, 16'd0, 16'd0);
		send_sample(16'd1000, 16'd0, 16'd0, 16'd0, 16'd0);
		send_sample(16'hFC18, 16'd0, 16'd0, 16'd0, 16'd0);
		send_sample(16'd0, 16'hFC18, 16'd0, 16'd0, 16'd0);
		send_sample(16'd0, 16'd1000, 16'd0, 16'd0, 16'd0);
		send_sample(16'd300, 16'd200, 16'd500, 16'd12869, 16'd12869);
		send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFF);

		// tilt off and minimum gain: sample reduces to the offsets; then maximum gain with extreme offsets, tilt off and on
		apply_setting(16'd0, 21'd0, 21'd0, 21'd0, 1'b0);
		send_sample(16'h7FFF, 16'h8000, 16'h1234, 16'd9000, 16'd9000);
		apply_setting(16'hFFFF, 21'h100000, 21'h0FFFFF, 21'h100000, 1'b0);
		send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'd0, 16'd0);
		send_sample(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
		apply_setting(16'hFFFF, 21'h0FFFFF, 21'h100000, 21'h0FFFFF, 1'b1);
		send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
		send_sample(16'h8000, 16'h8000, 16'h8000, 16'd25736, -16'sd25736);
		// unknown register index leaves the settings alone
		drain();
		write_reg(3'd5, 21'h1FFFFF);
		write_reg(3'd7, 21'h0AAAAA);
		send_sample(16'd400, 16'hFE00, 16'd100, 16'd3000, 16'hF000);

		// random settings, the reset values and an all-ones pattern among them
		apply_setting(16'd3768, 21'd0, 21'd0, 21'd0, 1'b1);
		random_burst(150);
		apply_setting(16'd4096, 21'h155555, 21'h0AAAAA, 21'h1FFFFF, 1'b1);
		random_burst(100);
		for (int ph = 0; ph < 7; ph++) begin
			apply_setting(16'($urandom), 21'($urandom), 21'($urandom), 21'($urandom),
				1'(ph % 3 != 0));
			random_burst(90);
		end

		drain();
		repeat (LATENCY + 10) @(posedge clk);
		$display("sent %0d samples over %0d register settings, %0d headings checked",
			samples_sent, settings_used, headings_seen);
		$display("covered tilt on and off, gain and offset extremes, zero field, all angle codes");
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
